// File: hw/rtl/pmmu_pkg.sv
// shared types, constants and helpers of the paged address translator
`timescale 1ns / 1ps
`default_nettype none
package pmmu_pkg;

	localparam int MODE_SETS      = 4;
	localparam int PHYS_ADDR_BITS = 22;
	localparam int PAGES          = 8;
	localparam int ENTRIES        = MODE_SETS * PAGES;
	localparam int IDX_W          = $clog2(ENTRIES);

	localparam int OP_W    = 3;
	localparam int MODE_W  = 2;
	localparam int VA_W    = 16;
	localparam int PAGE_W  = 3;
	localparam int LV_W    = 16;
	localparam int PA_W    = 22;
	localparam int RSN_W   = 2;
	localparam int BASE_W  = 12;
	localparam int DESC_W  = 11;
	localparam int FLAGS_W = 3;
	localparam int CFG_W   = 16;

	// (base + block) << 6 | displacement before the wrap
	localparam int RAW_PA_W = BASE_W + 1 + 6;
	localparam logic [RAW_PA_W-1:0] PHYS_MASK = RAW_PA_W'((64'd1 << PHYS_ADDR_BITS) - 64'd1);

	localparam logic [VA_W-1:0] STATUS_REG_RESET = 16'o177572;
	localparam logic [VA_W-1:0] BYTE_ADDR_MASK   = 16'hFFFE;

	// descriptor bit positions
	localparam int DESC_LEN_LSB = 4;
	localparam int DESC_WR_BIT  = 3;
	localparam int DESC_ED_BIT  = 2;

	typedef enum logic [OP_W-1:0] {
		OP_READ           = 3'd0,
		OP_READ_UNCHECKED = 3'd1,
		OP_WRITE_WORD     = 3'd2,
		OP_WRITE_BYTE     = 3'd3,
		OP_LOAD_BASE      = 3'd4,
		OP_LOAD_DESC      = 3'd5,
		OP_SET_PC         = 3'd6,
		OP_CLEAR_ABORT    = 3'd7
	} op_t;

	typedef enum logic [RSN_W-1:0] {
		RSN_NONE   = 2'd0,
		RSN_NONRES = 2'd1,
		RSN_LENGTH = 2'd2,
		RSN_RDONLY = 2'd3
	} reason_t;

	typedef enum logic [1:0] {
		KEY_NONRES = 2'd0,
		KEY_RDONLY = 2'd1,
		KEY_UNUSED = 2'd2,
		KEY_RW     = 2'd3
	} key_t;

	typedef enum logic {
		CFG_MAPPING = 1'b0,
		CFG_STATUS  = 1'b1
	} cfg_idx_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	// outcome of one access, from the check unit to the control
	typedef struct packed {
		logic [PA_W-1:0]  pa;
		logic [RSN_W-1:0] reason;
		logic             mark_set;
	} chk_t;

	function automatic logic [IDX_W-1:0] set_index(input logic [MODE_W-1:0] mode,
		input logic [PAGE_W-1:0] page);
		logic [MODE_W-1:0] m;
		m = mode;
		if (mode >= MODE_W'(MODE_SETS - 1))
			m = MODE_W'(MODE_SETS - 1);
		return IDX_W'({m, page});
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/pmmu_ifs.sv
// valid/ready channel interfaces for request and result beats
`timescale 1ns / 1ps
`default_nettype none
interface pmmu_in_if import pmmu_pkg::*;;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [MODE_W-1:0] access_mode;
	logic [VA_W-1:0]   virtual_address;
	logic [PAGE_W-1:0] page_select;
	logic [LV_W-1:0]   load_value;

	modport source(output valid, op, access_mode, virtual_address, page_select, load_value,
		input ready);
	modport sink(input valid, op, access_mode, virtual_address, page_select, load_value,
		output ready);
endinterface

interface pmmu_out_if import pmmu_pkg::*;;
	logic             valid;
	logic             ready;
	logic [PA_W-1:0]  physical_address;
	logic             aborted;
	logic [RSN_W-1:0] abort_reason;
	logic [VA_W-1:0]  virtual_pc;

	modport source(output valid, physical_address, aborted, abort_reason, virtual_pc,
		input ready);
	modport sink(input valid, physical_address, aborted, abort_reason, virtual_pc,
		output ready);
endinterface
`default_nettype wire

// File: hw/rtl/pmmu_ram.sv
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps
`default_nettype none
module pmmu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: hw/rtl/pmmu_check.sv
// translation, access checks and written-mark decision for one access
`timescale 1ns / 1ps
`default_nettype none
module pmmu_check import pmmu_pkg::*; (
	input  wire logic [OP_W-1:0]   op,
	input  wire logic [VA_W-1:0]   va,
	input  wire logic [BASE_W-1:0] base,
	input  wire logic [DESC_W-1:0] desc,
	input  wire logic              mapping,
	input  wire logic [VA_W-1:0]   status_addr,
	output chk_t                   chk
);

	logic [1:0]          key;
	logic [6:0]          len;
	logic [6:0]          block;
	logic                in_bounds;
	logic                is_access;
	logic                is_write;
	logic                checked;
	logic [RSN_W-1:0]    raw_reason;
	logic [RAW_PA_W-1:0] raw_pa;

	assign key   = desc[1:0];
	assign len   = desc[DESC_W-1:DESC_LEN_LSB];
	assign block = va[12:6];

	always_comb begin
		is_access = 1'b0;
		is_write  = 1'b0;
		checked   = 1'b0;
		case (op) inside
			OP_READ: begin
				is_access = 1'b1;
				checked   = 1'b1;
			end
			OP_READ_UNCHECKED: begin
				is_access = 1'b1;
			end
			OP_WRITE_WORD, OP_WRITE_BYTE: begin
				is_access = 1'b1;
				is_write  = 1'b1;
				checked   = 1'b1;
			end
			default: begin
				is_access = 1'b0;
			end
		endcase
	end

	// downward pages grow from the top of the page
	assign in_bounds = desc[DESC_ED_BIT] ? (block >= len) : (block <= len);

	always_comb begin
		if (key == KEY_NONRES || key == KEY_UNUSED)
			raw_reason = RSN_NONRES;
		else if (!in_bounds)
			raw_reason = RSN_LENGTH;
		else if (is_write && key != KEY_RW)
			raw_reason = RSN_RDONLY;
		else
			raw_reason = RSN_NONE;
	end

	assign raw_pa = ((RAW_PA_W'(base) + RAW_PA_W'(block)) << 6) | RAW_PA_W'(va[5:0]);

	always_comb begin
		chk.reason   = RSN_NONE;
		chk.pa       = '0;
		chk.mark_set = 1'b0;
		if (is_access) begin
			if (!mapping) begin
				chk.pa = PA_W'(va);
			end else begin
				// the status register itself is exempt from the written mark
				chk.mark_set = (op == OP_WRITE_WORD && va != status_addr)
					|| (op == OP_WRITE_BYTE && (va & BYTE_ADDR_MASK) != status_addr);
				if (checked)
					chk.reason = raw_reason;
				if (chk.reason == RSN_NONE)
					chk.pa = PA_W'(raw_pa & PHYS_MASK);
			end
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/paged_mmu_address_translator.sv
// order: a taken request beat reads the page rams, then executes and writes back, and its result
//   beat is registered; no new request is taken until that is done, nor while a result beat
//   waits unaccepted
// reset: page stores read as zero through per-entry valid bits cleared at once,
//   so no clearing pass; abort state, pc and result valid clear
`timescale 1ns / 1ps
`default_nettype none
module paged_mmu_address_translator import pmmu_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [CFG_W-1:0] cfg_wdata,
	pmmu_in_if.sink               in_ch,
	pmmu_out_if.source            out_ch
);

	state_t state_q, state_d;
	logic   in_ready;
	logic   exec;
	logic   in_fire;

	logic              mapping_q;
	logic [VA_W-1:0]   status_addr_q;

	logic [OP_W-1:0]   op_s1;
	logic [MODE_W-1:0] mode_s1;
	logic [VA_W-1:0]   va_s1;
	logic [LV_W-1:0]   lv_s1;
	logic [IDX_W-1:0]  idx_s1;

	logic [ENTRIES-1:0] base_valid_q;
	logic [ENTRIES-1:0] desc_valid_q;

	logic [IDX_W-1:0]  rd_idx;
	logic [BASE_W-1:0] base_rd;
	logic [DESC_W-1:0] desc_rd;
	logic [BASE_W-1:0] base_cur;
	logic [DESC_W-1:0] desc_cur;

	logic              base_we;
	logic              desc_we;
	logic [DESC_W-1:0] desc_wdata;

	chk_t chk;

	logic [FLAGS_W-1:0] abort_flags_q;
	logic [MODE_W-1:0]  abort_mode_q;
	logic [PAGE_W-1:0]  abort_page_q;
	logic [VA_W-1:0]    frozen_pc_q;
	logic [VA_W-1:0]    pc_next;

	logic             out_valid_q;
	logic [PA_W-1:0]  pa_q;
	logic             aborted_q;
	logic [RSN_W-1:0] reason_q;
	logic [VA_W-1:0]  vpc_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mapping_q     <= 1'b0;
			status_addr_q <= STATUS_REG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MAPPING: mapping_q     <= cfg_wdata[0];
				CFG_STATUS:  status_addr_q <= cfg_wdata;
				default:     mapping_q     <= mapping_q;
			endcase
		end
	end

	// control
	always_comb begin
		unique case (state_q)
			ST_IDLE: state_d = in_fire ? ST_EXEC : ST_IDLE;
			ST_EXEC: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		exec     = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = !out_valid_q || out_ch.ready;
			ST_EXEC: exec     = 1'b1;
			default: in_ready = 1'b0;
		endcase
	end

	assign in_ch.ready = in_ready;
	assign in_fire     = in_ch.valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// request capture and page ram read
	assign rd_idx = (in_ch.op == OP_LOAD_BASE || in_ch.op == OP_LOAD_DESC)
		? set_index(in_ch.access_mode, in_ch.page_select)
		: set_index(in_ch.access_mode, in_ch.virtual_address[VA_W-1:VA_W-PAGE_W]);

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1   <= in_ch.op;
			mode_s1 <= in_ch.access_mode;
			va_s1   <= in_ch.virtual_address;
			lv_s1   <= in_ch.load_value;
			idx_s1  <= rd_idx;
		end
	end

	pmmu_ram #(.WIDTH(BASE_W), .DEPTH(ENTRIES)) u_base_ram (
		.clk   (clk),
		.we    (base_we),
		.waddr (idx_s1),
		.wdata (lv_s1[BASE_W-1:0]),
		.re    (in_fire),
		.raddr (rd_idx),
		.rdata (base_rd)
	);

	pmmu_ram #(.WIDTH(DESC_W), .DEPTH(ENTRIES)) u_desc_ram (
		.clk   (clk),
		.we    (desc_we),
		.waddr (idx_s1),
		.wdata (desc_wdata),
		.re    (in_fire),
		.raddr (rd_idx),
		.rdata (desc_rd)
	);

	// never-written entries read as zero
	assign base_cur = base_valid_q[idx_s1] ? base_rd : '0;
	assign desc_cur = desc_valid_q[idx_s1] ? desc_rd : '0;

	pmmu_check u_check (
		.op          (op_s1),
		.va          (va_s1),
		.base        (base_cur),
		.desc        (desc_cur),
		.mapping     (mapping_q),
		.status_addr (status_addr_q),
		.chk         (chk)
	);

	// write-back
	assign base_we = exec && op_s1 == OP_LOAD_BASE;
	assign desc_we = exec && (op_s1 == OP_LOAD_DESC || chk.mark_set);

	always_comb begin
		if (op_s1 == OP_LOAD_DESC)
			desc_wdata = {lv_s1[14:8], 1'b0, lv_s1[3], lv_s1[2:1]};
		else
			desc_wdata = desc_cur | DESC_W'(1 << DESC_WR_BIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_valid_q <= '0;
			desc_valid_q <= '0;
		end else begin
			if (base_we)
				base_valid_q[idx_s1] <= 1'b1;
			if (desc_we)
				desc_valid_q[idx_s1] <= 1'b1;
		end
	end

	// abort state and pc; the pc stays frozen while any flag is up
	assign pc_next = (op_s1 == OP_SET_PC && abort_flags_q == '0) ? lv_s1 : frozen_pc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			abort_flags_q <= '0;
			abort_mode_q  <= '0;
			abort_page_q  <= '0;
			frozen_pc_q   <= '0;
		end else if (exec) begin
			frozen_pc_q <= pc_next;
			if (op_s1 == OP_CLEAR_ABORT) begin
				abort_flags_q <= '0;
				abort_mode_q  <= '0;
				abort_page_q  <= '0;
			end else if (chk.reason != RSN_NONE) begin
				if (abort_flags_q == '0) begin
					abort_mode_q <= mode_s1;
					abort_page_q <= va_s1[VA_W-1:VA_W-PAGE_W];
				end
				abort_flags_q <= abort_flags_q
					| FLAGS_W'(3'b100 >> (chk.reason - RSN_W'(1)));
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (exec)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			pa_q      <= chk.pa;
			aborted_q <= chk.reason != RSN_NONE;
			reason_q  <= chk.reason;
			vpc_q     <= pc_next;
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.physical_address = pa_q;
	assign out_ch.aborted          = aborted_q;
	assign out_ch.abort_reason     = reason_q;
	assign out_ch.virtual_pc       = vpc_q;

endmodule
`default_nettype wire

// File: hw/rtl/pmmu_checker.sv
// port-level assertions for the translator and their bind
`timescale 1ns / 1ps
`default_nettype none
module pmmu_checker import pmmu_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic [PA_W-1:0]  physical_address,
	input wire logic             aborted,
	input wire logic [RSN_W-1:0] abort_reason
);

	// a waiting result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(physical_address))
		else $error("result beat changed while stalled");

	// one request in flight: no new beat taken right after one
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while previous one executes");

	// each request yields its result beat once it has executed, not before
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid ##1 out_valid)
		else $error("result beat missing or early");

	// abort flag, reason and address agree
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (aborted == (abort_reason != RSN_NONE))
			&& (!aborted || physical_address == '0))
		else $error("abort fields inconsistent");

endmodule

bind paged_mmu_address_translator pmmu_checker u_pmmu_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_ch.valid),
	.in_ready         (in_ch.ready),
	.out_valid        (out_ch.valid),
	.out_ready        (out_ch.ready),
	.physical_address (out_ch.physical_address),
	.aborted          (out_ch.aborted),
	.abort_reason     (out_ch.abort_reason)
);
`default_nettype wire

// File: tb/paged_mmu_address_translator_test.sv
// self-checking testbench of the paged address translator
`timescale 1ns / 1ps
module paged_mmu_address_translator_test;
	import pmmu_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int SETTLE_TICKS = 4;

	typedef struct packed {
		op_t               op;
		logic [MODE_W-1:0] mode;
		logic [VA_W-1:0]   va;
		logic [PAGE_W-1:0] page;
		logic [LV_W-1:0]   lv;
	} access_t;

	typedef struct packed {
		logic [PA_W-1:0]  pa;
		logic             aborted;
		reason_t          reason;
		logic [VA_W-1:0]  pc;
	} outcome_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	cfg_idx_t         cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	pmmu_in_if  req_ch();
	pmmu_out_if res_ch();

	paged_mmu_address_translator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_ch    (req_ch),
		.out_ch   (res_ch)
	);

	// shadow of the translator state
	logic [BASE_W-1:0]  base_ram [ENTRIES];
	logic [DESC_W-1:0]  desc_ram [ENTRIES];
	logic [FLAGS_W-1:0] trap_flags;
	logic [MODE_W-1:0]  trap_mode;
	logic [PAGE_W-1:0]  trap_page;
	logic [VA_W-1:0]    pc_shadow;
	logic               mapping_on;
	logic [VA_W-1:0]    status_addr;

	outcome_t pending_results[$];
	int       fail_count;
	int       idle_cycles;
	bit       steady;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic int entry_of(logic [MODE_W-1:0] mode, logic [PAGE_W-1:0] page);
		int m;
		m = mode;
		if (m > MODE_SETS - 1)
			m = MODE_SETS - 1;
		return m * PAGES + page;
	endfunction

	function automatic logic [LV_W-1:0] desc_word(int len, bit down, key_t key);
		return {1'b0, 7'(len), 4'b0, down, key, 1'b0};
	endfunction

	// advances the shadow state by one access and returns its outcome
	function automatic outcome_t translate_beat(access_t a);
		outcome_t res;
		int idx;
		int sel;
		logic [DESC_W-1:0] d;
		logic [6:0] blk;
		logic [PA_W-1:0] sum;
		key_t key;
		res = '0;
		res.reason = RSN_NONE;
		idx = entry_of(a.mode, a.va[15:13]);
		sel = entry_of(a.mode, a.page);
		blk = a.va[12:6];
		case (a.op)
			OP_READ, OP_READ_UNCHECKED, OP_WRITE_WORD, OP_WRITE_BYTE: begin
				if (!mapping_on) begin
					res.pa = PA_W'(a.va);
				end else begin
					if ((a.op == OP_WRITE_WORD && a.va != status_addr) ||
						(a.op == OP_WRITE_BYTE && (a.va & BYTE_ADDR_MASK) != status_addr))
						desc_ram[idx][DESC_WR_BIT] = 1'b1;
					d = desc_ram[idx];
					key = key_t'(d[1:0]);
					if (a.op != OP_READ_UNCHECKED) begin
						if (key == KEY_NONRES || key == KEY_UNUSED)
							res.reason = RSN_NONRES;
						else if (d[DESC_ED_BIT] ? (blk < d[10:4]) : (blk > d[10:4]))
							res.reason = RSN_LENGTH;
						else if ((a.op == OP_WRITE_WORD || a.op == OP_WRITE_BYTE) &&
							key != KEY_RW)
							res.reason = RSN_RDONLY;
					end
					if (res.reason != RSN_NONE) begin
						if (trap_flags == '0) begin
							trap_mode = a.mode;
							trap_page = a.va[15:13];
						end
						case (res.reason)
							RSN_NONRES: trap_flags[2] = 1'b1;
							RSN_LENGTH: trap_flags[1] = 1'b1;
							default:    trap_flags[0] = 1'b1;
						endcase
						res.aborted = 1'b1;
					end else begin
						sum = PA_W'(base_ram[idx]) + PA_W'(blk);
						res.pa = {sum[PA_W-7:0], a.va[5:0]};
					end
				end
			end
			OP_LOAD_BASE: base_ram[sel] = a.lv[BASE_W-1:0];
			OP_LOAD_DESC: desc_ram[sel] = {a.lv[14:8], 1'b0, a.lv[3], a.lv[2:1]};
			OP_SET_PC: begin
				if (trap_flags == '0)
					pc_shadow = a.lv;
			end
			default: begin
				trap_flags = '0;
				trap_mode = '0;
				trap_page = '0;
			end
		endcase
		res.pc = pc_shadow;
		return res;
	endfunction

	task automatic send_beat(access_t a);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid           <= 1'b1;
		req_ch.op              <= a.op;
		req_ch.access_mode     <= a.mode;
		req_ch.virtual_address <= a.va;
		req_ch.page_select     <= a.page;
		req_ch.load_value      <= a.lv;
		do
			@(posedge clk);
		while (!req_ch.ready);
		pending_results.push_back(translate_beat(a));
	endtask

	task automatic send_op(op_t op, logic [MODE_W-1:0] mode, logic [VA_W-1:0] va,
		logic [PAGE_W-1:0] page, logic [LV_W-1:0] lv);
		access_t a;
		a = '{op: op, mode: mode, va: va, page: page, lv: lv};
		send_beat(a);
	endtask

	// drop valid and wait until every beat has come back
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MAPPING)
			mapping_on = val[0];
		else
			status_addr = val;
	endtask

	function automatic access_t random_beat();
		access_t a;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		a.mode = MODE_W'($urandom);
		a.va   = VA_W'($urandom);
		a.page = PAGE_W'($urandom);
		a.lv   = LV_W'($urandom);
		if (pick < 20)
			a.op = OP_READ;
		else if (pick < 28)
			a.op = OP_READ_UNCHECKED;
		else if (pick < 43)
			a.op = OP_WRITE_WORD;
		else if (pick < 53)
			a.op = OP_WRITE_BYTE;
		else if (pick < 63)
			a.op = OP_LOAD_BASE;
		else if (pick < 78)
			a.op = OP_LOAD_DESC;
		else if (pick < 88)
			a.op = OP_SET_PC;
		else
			a.op = OP_CLEAR_ABORT;
		// hit the status register word or its odd byte now and then
		if ($urandom_range(0, 9) == 0)
			a.va = status_addr | VA_W'($urandom_range(0, 1));
		return a;
	endfunction

	task automatic test_passthrough();
		send_op(OP_READ, 0, 16'h0000, 0, 16'h0000);
		send_op(OP_WRITE_WORD, 3, 16'hFFFF, 7, 16'hFFFF);
		send_op(OP_WRITE_BYTE, 1, STATUS_REG_RESET | 16'h0001, 0, 16'h0000);
		send_op(OP_READ_UNCHECKED, 2, 16'hA5A5, 5, 16'h5A5A);
		write_reg(CFG_MAPPING, 16'h0001);
	endtask

	task automatic test_translation();
		send_op(OP_LOAD_BASE, 0, 16'h0000, 7, 16'hFFFF);
		send_op(OP_LOAD_DESC, 0, 16'h0000, 7, desc_word(127, 0, KEY_RW));
		send_op(OP_READ, 0, 16'hFFFF, 0, 16'h0000);
		// status register word and byte writes
		send_op(OP_WRITE_WORD, 0, STATUS_REG_RESET, 0, 16'h0000);
		send_op(OP_WRITE_BYTE, 0, STATUS_REG_RESET | 16'h0001, 0, 16'h0000);
		// all descriptor bits set: downward, full length, read/write
		send_op(OP_LOAD_DESC, 3, 16'h0000, 0, 16'hFFFF);
		send_op(OP_READ, 3, 16'h1FC0, 0, 16'h0000);
	endtask

	task automatic test_access_checks();
		send_op(OP_LOAD_DESC, 1, 16'h0000, 0, desc_word(5, 0, KEY_RDONLY));
		send_op(OP_LOAD_BASE, 1, 16'h0000, 0, 16'h0123);
		send_op(OP_READ, 1, 16'h0140, 0, 16'h0000);
		send_op(OP_READ, 1, 16'h0180, 0, 16'h0000);
		send_op(OP_READ_UNCHECKED, 1, 16'h0180, 0, 16'h0000);
		send_op(OP_WRITE_WORD, 1, 16'h0000, 0, 16'h0000);
		send_op(OP_LOAD_DESC, 2, 16'h0000, 1, desc_word(10, 1, KEY_RW));
		send_op(OP_READ, 2, 16'h2240, 0, 16'h0000);
		send_op(OP_WRITE_BYTE, 2, 16'h2280, 0, 16'h0000);
		send_op(OP_LOAD_DESC, 2, 16'h0000, 2, desc_word(0, 0, KEY_UNUSED));
		send_op(OP_READ, 2, 16'h4000, 0, 16'h0000);
	endtask

	task automatic test_abort_latching();
		send_op(OP_CLEAR_ABORT, 0, 16'h0000, 0, 16'h0000);
		send_op(OP_SET_PC, 0, 16'h0000, 0, 16'h1234);
		send_op(OP_READ, 0, 16'h2000, 0, 16'h0000);
		// pc frozen, flags pile up
		send_op(OP_SET_PC, 0, 16'h0000, 0, 16'hBEEF);
		send_op(OP_WRITE_WORD, 1, 16'h0000, 0, 16'h0000);
		send_op(OP_CLEAR_ABORT, 0, 16'h0000, 0, 16'h0000);
		send_op(OP_SET_PC, 0, 16'h0000, 0, 16'hFFFF);
	endtask

	task automatic test_random_traffic();
		logic [CFG_W-1:0] addr;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0:       addr = 16'h0000;
				1:       addr = 16'hFFFF;
				2:       addr = STATUS_REG_RESET;
				default: addr = CFG_W'($urandom);
			endcase
			write_reg(CFG_STATUS, addr);
			write_reg(CFG_MAPPING, (phase % 3 == 1) ? 16'h0000 : 16'h0001);
			for (int n = 0; n < 250; n++) begin
				if (n % 50 == 0)
					steady = ($urandom_range(0, 3) == 0);
				send_beat(random_beat());
			end
			steady = 1'b0;
		end
	endtask

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			base_ram[i] = '0;
			desc_ram[i] = '0;
		end
		trap_flags  = '0;
		trap_mode   = '0;
		trap_page   = '0;
		pc_shadow   = '0;
		mapping_on  = 1'b0;
		status_addr = STATUS_REG_RESET;
		fail_count  = 0;
		steady      = 1'b0;
		arst_n                 <= 1'b0;
		cfg_we                 <= 1'b0;
		cfg_index              <= CFG_MAPPING;
		cfg_wdata              <= '0;
		req_ch.valid           <= 1'b0;
		req_ch.op              <= OP_READ;
		req_ch.access_mode     <= '0;
		req_ch.virtual_address <= '0;
		req_ch.page_select     <= '0;
		req_ch.load_value      <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_passthrough();
		test_translation();
		test_access_checks();
		test_abort_latching();
		test_random_traffic();
		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("paged_mmu_address_translator: match");
		end else begin
			$display("paged_mmu_address_translator: mismatch");
		end
		$finish;
	end

	// result side back-pressure
	initial begin
		int stall;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!res_ch.valid);
		end
	end

	always @(posedge clk) begin
		outcome_t want;
		if (res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result beat pa=%h", $time, res_ch.physical_address);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (res_ch.physical_address !== want.pa) begin
					$display("%0t: physical_address expected %h actual %h", $time, want.pa,
						res_ch.physical_address);
					fail_count++;
				end
				if (res_ch.aborted !== want.aborted) begin
					$display("%0t: aborted expected %b actual %b", $time, want.aborted,
						res_ch.aborted);
					fail_count++;
				end
				if (res_ch.abort_reason !== want.reason) begin
					$display("%0t: abort_reason expected %0d actual %0d", $time, want.reason,
						res_ch.abort_reason);
					fail_count++;
				end
				if (res_ch.virtual_pc !== want.pc) begin
					$display("%0t: virtual_pc expected %h actual %h", $time, want.pc,
						res_ch.virtual_pc);
					fail_count++;
				end
			end
		end
	end

	// hang detection: too long without any beat on either side
	initial idle_cycles = 0;
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("paged_mmu_address_translator: mismatch");
				$finish;
			end
		end
	end

endmodule
